[rtl/srle_pkg.sv]
// Shared types, constants and character helpers for the S2 record line encoder.
// Used by the interfaces' users: srle_plan, srle_emit and the top level.
package srle_pkg;

    localparam int BPL_DEF = 32;
    localparam int LEN_W   = 25;
    localparam int OFF_W   = 24;
    localparam int SUM_W   = 32;

    localparam logic [LEN_W-1:0] LEN_ONE = 25'd1;
    localparam logic [LEN_W-1:0] LEN_MAX = 25'h100_0000;
    localparam logic [7:0] CNT_EXTRA = 8'd4;

    // ASCII codes
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_A_OFS = 8'h37;   // 'A' minus ten

    typedef enum logic [2:0] {
        PH_START,
        PH_HDR,
        PH_DATA,
        PH_TRL,
        PH_END
    } t_phase;

    typedef logic [3:0] t_idx;

    // Everything the serializer needs to print the text of one item
    typedef struct packed {
        logic             start;
        logic             hdr;
        logic             trl;
        logic             endr;
        logic [7:0]       cnt;
        logic [OFF_W-1:0] addr;
        logic [7:0]       data;
        logic [7:0]       cks;
        logic [SUM_W-1:0] sum;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_char = CH_0 + {4'd0, nib};
        end else begin
            hex_char = CH_A_OFS + {4'd0, nib};
        end
    endfunction

    // Fixed start / end record text, newline included
    function automatic logic [7:0] rec_char(input logic is_end, input t_idx idx);
        case (idx)
            4'd0:    rec_char = CH_S;
            4'd1:    rec_char = is_end ? CH_8 : CH_2;
            4'd3:    rec_char = CH_4;
            4'd10:   rec_char = CH_F;
            4'd11:   rec_char = CH_B;
            4'd12:   rec_char = CH_NL;
            default: rec_char = CH_0;
        endcase
    endfunction

    function automatic t_idx phase_last_idx(input t_phase ph);
        case (ph)
            PH_START: phase_last_idx = 4'd12;
            PH_HDR:   phase_last_idx = 4'd9;
            PH_DATA:  phase_last_idx = 4'd1;
            PH_TRL:   phase_last_idx = 4'd2;
            PH_END:   phase_last_idx = 4'd12;
            default:  phase_last_idx = 4'd0;
        endcase
    endfunction

endpackage

[rtl/srle_if.sv]
// Valid/ready channel interfaces for the S2 record line encoder.
// Input channel carries raw bytes, output channel carries text characters.
interface srle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface srle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  text_char;
    logic        last_of_run;
    logic        image_done;
    logic [31:0] prom_sum;

    modport source (output valid, output text_char, output last_of_run,
                    output image_done, output prom_sum, input ready);
    modport sink   (input valid, input text_char, input last_of_run,
                    input image_done, input prom_sum, output ready);
endinterface

[rtl/srle_plan.sv]
// Input stage: holds image position, line checksum and running sum, and
// turns each accepted byte into a print job. Depends on srle_pkg, srle_if.
module srle_plan import srle_pkg::*; #(
    parameter int BYTES_PER_LINE = BPL_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    srle_in_if.sink          i_in,
    input  logic             i_take,
    output logic             o_job_vld,
    output t_job             o_job
);

    localparam int LPW = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
    localparam logic [LPW-1:0]   LP_LAST = LPW'(BYTES_PER_LINE - 1);
    localparam logic [LEN_W-1:0] BPL_LEN = LEN_W'(BYTES_PER_LINE);

    logic [LEN_W-1:0] r_len;
    logic [OFF_W-1:0] r_off,  n_off;
    logic [LPW-1:0]   r_lpos, n_lpos;
    logic [7:0]       r_cks,  n_cks;
    logic [SUM_W-1:0] r_sum,  n_sum;
    logic             r_job_vld;
    t_job             r_job,  n_job;

    logic [LEN_W-1:0] len_eff, off_ext, rem, rem_c, next_off;
    logic [7:0]       cnt, hdr_sum;
    logic             first, hdr, ended, trl, acc;

    assign i_in.ready = !r_job_vld || i_take;
    assign acc        = i_in.valid && i_in.ready;

    always_comb begin
        if (r_len == '0) begin
            len_eff = LEN_ONE;
        end else if (r_len > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = r_len;
        end

        off_ext = {1'b0, r_off};
        first   = (r_off == '0);
        hdr     = (r_lpos == '0);

        // bytes left in the image, clipped to one line
        rem   = (len_eff > off_ext) ? (len_eff - off_ext) : LEN_ONE;
        rem_c = (rem > BPL_LEN) ? BPL_LEN : rem;
        cnt   = rem_c[7:0] + CNT_EXTRA;

        hdr_sum = cnt + r_off[23:16] + r_off[15:8] + r_off[7:0];
        n_cks   = (hdr ? hdr_sum : r_cks) + i_in.data_byte;
        n_sum   = (first ? '0 : r_sum) + {24'd0, i_in.data_byte};

        next_off = off_ext + LEN_ONE;
        ended    = (next_off >= len_eff);
        trl      = ended || (r_lpos == LP_LAST);

        n_off  = ended ? '0 : next_off[OFF_W-1:0];
        n_lpos = trl ? '0 : r_lpos + LPW'(1);

        n_job.start = first;
        n_job.hdr   = hdr;
        n_job.trl   = trl;
        n_job.endr  = ended;
        n_job.cnt   = cnt;
        n_job.addr  = r_off;
        n_job.data  = i_in.data_byte;
        n_job.cks   = ~n_cks;
        n_job.sum   = n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_ONE;
            r_off     <= '0;
            r_lpos    <= '0;
            r_cks     <= '0;
            r_sum     <= '0;
            r_job_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (acc) begin
                r_off     <= n_off;
                r_lpos    <= n_lpos;
                r_cks     <= n_cks;
                r_sum     <= n_sum;
                r_job_vld <= 1'b1;
            end else if (i_take) begin
                r_job_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_job <= n_job;
        end
    end

    assign o_job_vld = r_job_vld;
    assign o_job     = r_job;

endmodule

[rtl/srle_emit.sv]
// Character serializer: walks the record phases of a job and feeds the output
// register one character per cycle while ready. Depends on srle_pkg, srle_if.
module srle_emit import srle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_vld,
    input  t_job       i_job,
    output logic       o_take,
    srle_out_if.source o_out
);

    logic             r_busy;
    t_job             r_cur;
    t_phase           r_ph,  n_ph;
    t_idx             r_idx, n_idx;
    logic             r_ovld;
    logic [7:0]       r_char, n_char;
    logic             r_last;
    logic             r_done;
    logic [SUM_W-1:0] r_psum;

    logic adv, emit, ph_end, cur_last;

    assign adv    = !r_ovld || o_out.ready;
    assign emit   = adv && r_busy;
    assign ph_end = (r_idx == phase_last_idx(r_ph));

    always_comb begin
        cur_last = 1'b0;
        case (r_ph)
            PH_DATA: cur_last = (r_idx == 4'd1) && !r_cur.trl && !r_cur.endr;
            PH_TRL:  cur_last = (r_idx == 4'd2) && !r_cur.endr;
            PH_END:  cur_last = (r_idx == 4'd12);
            default: cur_last = 1'b0;
        endcase
    end

    // load a job when idle, or in the cycle the last character is printed
    assign o_take = i_job_vld && (!r_busy || (emit && cur_last));

    always_comb begin
        case (r_ph)
            PH_START: n_char = rec_char(1'b0, r_idx);
            PH_END:   n_char = rec_char(1'b1, r_idx);
            PH_HDR: begin
                case (r_idx)
                    4'd0:    n_char = CH_S;
                    4'd1:    n_char = CH_2;
                    4'd2:    n_char = hex_char(r_cur.cnt[7:4]);
                    4'd3:    n_char = hex_char(r_cur.cnt[3:0]);
                    4'd4:    n_char = hex_char(r_cur.addr[23:20]);
                    4'd5:    n_char = hex_char(r_cur.addr[19:16]);
                    4'd6:    n_char = hex_char(r_cur.addr[15:12]);
                    4'd7:    n_char = hex_char(r_cur.addr[11:8]);
                    4'd8:    n_char = hex_char(r_cur.addr[7:4]);
                    default: n_char = hex_char(r_cur.addr[3:0]);
                endcase
            end
            PH_DATA: n_char = (r_idx == 4'd0) ? hex_char(r_cur.data[7:4])
                                              : hex_char(r_cur.data[3:0]);
            PH_TRL: begin
                case (r_idx)
                    4'd0:    n_char = hex_char(r_cur.cks[7:4]);
                    4'd1:    n_char = hex_char(r_cur.cks[3:0]);
                    default: n_char = CH_NL;
                endcase
            end
            default: n_char = CH_NL;
        endcase
    end

    always_comb begin
        n_ph  = r_ph;
        n_idx = r_idx + 4'd1;
        if (ph_end) begin
            n_idx = '0;
            case (r_ph)
                PH_START: n_ph = r_cur.hdr ? PH_HDR : PH_DATA;
                PH_HDR:   n_ph = PH_DATA;
                PH_DATA:  n_ph = r_cur.trl ? PH_TRL : PH_END;
                PH_TRL:   n_ph = PH_END;
                default:  n_ph = r_ph;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= PH_DATA;
            r_idx  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (o_take) begin
                r_busy <= 1'b1;
                r_ph   <= i_job.start ? PH_START : (i_job.hdr ? PH_HDR : PH_DATA);
                r_idx  <= '0;
            end else if (emit && cur_last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_ph   <= n_ph;
                r_idx  <= n_idx;
            end

            if (emit) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cur <= i_job;
        end
        if (emit) begin
            r_char <= n_char;
            r_last <= cur_last;
            r_done <= cur_last && r_cur.endr;
            r_psum <= r_cur.sum;
        end
    end

    assign o_out.valid       = r_ovld;
    assign o_out.text_char   = r_char;
    assign o_out.last_of_run = r_last;
    assign o_out.image_done  = r_done;
    assign o_out.prom_sum    = r_psum;

    a_hdr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_ph == PH_HDR) |-> r_cur.hdr)
        else $error("header phase on a job without header");

    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_ph == PH_START) |-> r_cur.start)
        else $error("start record on a job that does not open an image");

    a_end_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_ph == PH_END) |-> r_cur.endr)
        else $error("end record on a job that does not close the image");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= phase_last_idx(r_ph)))
        else $error("character index past end of phase");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_done) |-> r_last)
        else $error("image done flagged on a character that is not the last of its item");

endmodule

[rtl/srecord_s2_line_encoder.sv]
// S2 record line encoder top level: byte in, ASCII S-record text out.
// An item passes the plan job register and the emit job register to the output.
// Throughput: one character per cycle while the output is ready; an item prints 2
// to 41 characters (data digits, plus header, trailer, start/end records if due).
// A one-deep job register lets the next byte be accepted while text is printing.
// Reset (synchronous, active low) clears position, sums and handshakes; length = 1.
module srecord_s2_line_encoder import srle_pkg::*; #(
    parameter int BYTES_PER_LINE = BPL_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    srle_in_if.sink          i_in,
    srle_out_if.source       o_out
);

    logic job_vld;
    logic take;
    t_job job;

    srle_plan #(
        .BYTES_PER_LINE (BYTES_PER_LINE)
    ) u_plan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_take      (take),
        .o_job_vld   (job_vld),
        .o_job       (job)
    );

    srle_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (job_vld),
        .i_job     (job),
        .o_take    (take),
        .o_out     (o_out)
    );

endmodule

[tb/sv/tb_srecord_s2_line_encoder.sv]
// Testbench for the S2 record line encoder: feeds raw bytes, checks every text character.
// A built-in byte-to-text predictor sets the expected characters, flags and sums.
// Depends on srle_pkg, srle_in_if / srle_out_if and srecord_s2_line_encoder.
`timescale 1ns / 100ps

module tb_srecord_s2_line_encoder;
    import srle_pkg::*;

    localparam int LINE_BYTES   = BPL_DEF;
    localparam int RANDOM_ITEMS = 480;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PRINT_LIMIT  = 40;

    typedef enum logic {ROW_CFG, ROW_BYTE} t_row_kind;
    typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PATTERN} t_sink_mode;

    typedef struct packed {
        logic [7:0]       ch;
        logic             last;
        logic             done;
        logic [SUM_W-1:0] sum;
    } t_text_item;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LEN_W-1:0] i_cfg_wdata;

    srle_in_if  in_ch ();
    srle_out_if out_ch ();

    srecord_s2_line_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: mirrors what the encoder holds
    logic [LEN_W-1:0] len_reg;
    logic [OFF_W-1:0] next_offset;
    logic [7:0]       line_sum8;
    logic [SUM_W-1:0] image_sum;
    logic [7:0]       run_buf [$];
    logic             run_ended;
    string            hex_digits = "0123456789ABCDEF";

    t_text_item expected_text [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         bytes_sent = 0;

    // Sender pacing
    int burst_left = 0;
    bit steady = 1'b0;

    // Receiver pacing
    int         hold_asks = 0;
    int         holds_done = 0;
    int         hold_left = 0;
    int         mode_left = 0;
    t_sink_mode sink_mode = SINK_OPEN;
    logic [4:0] stall_pat = 5'b10101;

    // Directed table
    t_row_kind        dir_kind [$];
    logic [LEN_W-1:0] dir_val [$];
    string            dir_text [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) run_buf.push_back(s[k]);
    endtask

    task automatic put_hex(input logic [7:0] v);
        run_buf.push_back(hex_digits[v[7:4]]);
        run_buf.push_back(hex_digits[v[3:0]]);
    endtask

    // Text produced by one raw byte; updates the predictor state
    task automatic encode_byte(input logic [7:0] b);
        logic [LEN_W-1:0] eff;
        logic [LEN_W-1:0] rem;
        logic [LEN_W-1:0] nxt;
        logic [7:0]       cnt;
        run_buf.delete();
        if (len_reg == '0)
            eff = LEN_ONE;
        else if (len_reg > LEN_MAX)
            eff = LEN_MAX;
        else
            eff = len_reg;

        if (next_offset == '0) begin
            image_sum = '0;
            put_text("S204000000FB\n");
        end
        if (int'(next_offset) % LINE_BYTES == 0) begin
            rem = (eff > {1'b0, next_offset}) ? eff - {1'b0, next_offset} : LEN_ONE;
            if (rem > LINE_BYTES) rem = LEN_W'(LINE_BYTES);
            cnt = rem[7:0] + CNT_EXTRA;
            put_text("S2");
            put_hex(cnt);
            put_hex(next_offset[23:16]);
            put_hex(next_offset[15:8]);
            put_hex(next_offset[7:0]);
            line_sum8 = cnt + next_offset[23:16] + next_offset[15:8] + next_offset[7:0];
        end

        image_sum = image_sum + {24'd0, b};
        line_sum8 = line_sum8 + b;
        put_hex(b);

        nxt = {1'b0, next_offset} + LEN_ONE;
        run_ended = (nxt >= eff);
        if (run_ended || int'(nxt) % LINE_BYTES == 0) begin
            put_hex(~line_sum8);
            run_buf.push_back(CH_NL);
        end
        if (run_ended) begin
            put_text("S804000000FB\n");
            next_offset = '0;
        end else begin
            next_offset = nxt[OFF_W-1:0];
        end
    endtask

    // Queue the expected characters; typed text, where given, replaces the predicted text
    task automatic queue_expected(input logic [7:0] b, input string typed);
        t_text_item it;
        int         n;
        encode_byte(b);
        n = (typed.len() != 0) ? typed.len() : run_buf.size();
        for (int k = 0; k < n; k++) begin
            it.ch   = (typed.len() != 0) ? typed[k] : run_buf[k];
            it.last = (k == n - 1);
            it.done = it.last && run_ended;
            it.sum  = image_sum;
            expected_text.push_back(it);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input string typed);
        int gap;
        gap = 0;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        @(negedge i_clk);
        while (!in_ch.ready) @(negedge i_clk);
        queue_expected(b, typed);
        bytes_sent++;
        @(posedge i_clk);
    endtask

    // Hold the input until every expected character is out, then let the pipe settle
    task automatic drain_text();
        in_ch.valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] v);
        drain_text();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        len_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [LEN_W-1:0] v,
                           input string typed);
        dir_kind.push_back(kind);
        dir_val.push_back(v);
        dir_text.push_back(typed);
    endtask

    // Receiver: long hold on request, otherwise a stall pattern that changes now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != holds_done) begin
            holds_done   <= hold_asks;
            hold_left    <= LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode <= t_sink_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 128);
                stall_pat <= 5'($urandom_range(1, 31));
            end else begin
                mode_left <= mode_left - 1;
                stall_pat <= {stall_pat[0], stall_pat[4:1]};
            end
            case (sink_mode)
                SINK_OPEN:  out_ch.ready <= 1'b1;
                SINK_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
                SINK_HEAVY: out_ch.ready <= ($urandom_range(0, 9) < 3);
                default:    out_ch.ready <= stall_pat[0];
            endcase
        end
    end

    // Outputs are stable between edges; sample the handshake at the falling edge
    always @(negedge i_clk) begin : check_text
        t_text_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_text.size() == 0) begin
                report_mismatch("char with none expected", {24'd0, out_ch.text_char}, '0);
            end else begin
                want = expected_text.pop_front();
                if (out_ch.text_char !== want.ch)
                    report_mismatch("text_char", {24'd0, out_ch.text_char}, {24'd0, want.ch});
                if (out_ch.last_of_run !== want.last)
                    report_mismatch("last_of_run", {31'd0, out_ch.last_of_run},
                                    {31'd0, want.last});
                if (out_ch.image_done !== want.done)
                    report_mismatch("image_done", {31'd0, out_ch.image_done},
                                    {31'd0, want.done});
                if (out_ch.prom_sum !== want.sum)
                    report_mismatch("prom_sum", out_ch.prom_sum, want.sum);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_srecord_s2_line_encoder: errors");
            $finish;
        end
    end

    initial begin : main_seq
        logic [LEN_W-1:0] new_len;
        logic [LEN_W-1:0] eff;
        logic [LEN_W-1:0] remain;
        int               n;
        bit               held;
        held = 1'b0;
        len_reg = LEN_ONE;
        next_offset = '0;
        line_sum8 = '0;
        image_sum = '0;
        run_ended = 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Length 1 after reset: each byte is a whole image
        add_row(ROW_BYTE, 25'h00, "S204000000FB\nS20500000000FA\nS804000000FB\n");
        add_row(ROW_BYTE, 25'hFF, "S204000000FB\nS205000000FFFB\nS804000000FB\n");
        // Zero length acts as one
        add_row(ROW_CFG, 25'd0, "");
        add_row(ROW_BYTE, 25'h5A, "S204000000FB\nS2050000005AA0\nS804000000FB\n");
        add_row(ROW_CFG, 25'd2, "");
        add_row(ROW_BYTE, 25'h80, "");
        add_row(ROW_BYTE, 25'h7F, "");
        // All ones clamps to the largest image
        add_row(ROW_CFG, 25'h1FF_FFFF, "");
        add_row(ROW_BYTE, 25'hA5, "S204000000FB\nS224000000A5");
        add_row(ROW_BYTE, 25'h3C, "");
        // Shrink mid-image: image ends on the next byte, mid-line
        add_row(ROW_CFG, 25'd1, "");
        add_row(ROW_BYTE, 25'hC3, "");
        add_row(ROW_CFG, LEN_MAX, "");
        add_row(ROW_BYTE, 25'h00, "S204000000FB\nS22400000000");
        add_row(ROW_BYTE, 25'h01, "");
        add_row(ROW_BYTE, 25'h80, "");
        add_row(ROW_BYTE, 25'h7F, "");
        add_row(ROW_BYTE, 25'hFE, "");
        add_row(ROW_CFG, 25'd3, "");
        add_row(ROW_BYTE, 25'h11, "");
        // Grow mid-image: header count no longer matches the bytes sent
        add_row(ROW_BYTE, 25'h22, "");
        add_row(ROW_BYTE, 25'h33, "");
        add_row(ROW_CFG, 25'd5, "");
        add_row(ROW_BYTE, 25'h44, "");
        add_row(ROW_BYTE, 25'h55, "");
        add_row(ROW_BYTE, 25'h66, "");
        add_row(ROW_CFG, 25'd2, "");
        add_row(ROW_BYTE, 25'hAA, "");
        add_row(ROW_BYTE, 25'h55, "");

        for (int r = 0; r < dir_kind.size(); r++) begin
            if (dir_kind[r] == ROW_CFG)
                write_length(dir_val[r]);
            else
                send_byte(dir_val[r][7:0], dir_text[r]);
        end

        bytes_sent = 0;
        while (bytes_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 9))
                        0:       new_len = '0;
                        1:       new_len = 25'd1;
                        2:       new_len = 25'd2;
                        3:       new_len = 25'd31;
                        4:       new_len = 25'd32;
                        5:       new_len = 25'd33;
                        6:       new_len = 25'd64;
                        7:       new_len = 25'd65;
                        8:       new_len = LEN_MAX;
                        default: new_len = 25'h1FF_FFFF;
                    endcase
                end
                1:       new_len = {1'b0, next_offset};
                2:       new_len = {1'b0, next_offset} + LEN_W'($urandom_range(1, 40));
                default: new_len = LEN_W'($urandom_range(1, 80));
            endcase
            write_length(new_len);

            if (new_len == '0)
                eff = LEN_ONE;
            else if (new_len > LEN_MAX)
                eff = LEN_MAX;
            else
                eff = new_len;
            remain = (eff > {1'b0, next_offset}) ? eff - {1'b0, next_offset} : LEN_ONE;

            // Mostly the rest of the image (at most 90 bytes); else to a line end or random
            case ($urandom_range(0, 9))
                0, 1:    n = LINE_BYTES - int'(next_offset) % LINE_BYTES;
                2:       n = $urandom_range(1, 40);
                default: n = (remain > 90) ? $urandom_range(20, 90) : int'(remain);
            endcase
            if (n > RANDOM_ITEMS - bytes_sent)
                n = RANDOM_ITEMS - bytes_sent;

            steady = ($urandom_range(0, 3) == 0);
            if (!held && n >= 12) begin
                hold_asks <= hold_asks + 1;
                steady = 1'b1;
                held = 1'b1;
            end
            repeat (n) send_byte(8'($urandom_range(0, 255)), "");
        end

        drain_text();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_srecord_s2_line_encoder: clean");
        else
            $display("tb_srecord_s2_line_encoder: errors");
        $finish;
    end

endmodule
